>>> rtl/core/rme_pkg.sv
// Package with payload types, constants and the arctangent table for the Euler angle core.
`default_nettype none
package rme_pkg;

   typedef struct packed {
      logic signed [15:0] r00;
      logic signed [15:0] r01;
      logic signed [15:0] r02;
      logic signed [15:0] r10;
      logic signed [15:0] r11;
      logic signed [15:0] r12;
      logic signed [15:0] r22;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] pitch_angle;
      logic signed [15:0] yaw_angle;
      logic signed [15:0] roll_angle;
      logic               gimbal_lock;
   } rsp_word_type;

   localparam int TABLE_LEN = 24;
   localparam int CW = 27;
   localparam int ZW = 26;
   localparam logic signed [ZW-1:0] HALF_TURN = ZW'(180 * 65536);
   localparam logic signed [15:0] OUT_LIMIT = 16'sd23040;
   localparam logic [14:0] THRESH_RESET = 15'd16;
   localparam logic [28:0] ONE_SQ = 29'd268435456;

   function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
      logic signed [ZW-1:0] v;
      case (idx)
         5'd0: v = 26'sd2949120;
         5'd1: v = 26'sd1740967;
         5'd2: v = 26'sd919879;
         5'd3: v = 26'sd466945;
         5'd4: v = 26'sd234379;
         5'd5: v = 26'sd117304;
         5'd6: v = 26'sd58666;
         5'd7: v = 26'sd29335;
         5'd8: v = 26'sd14668;
         5'd9: v = 26'sd7334;
         5'd10: v = 26'sd3667;
         5'd11: v = 26'sd1833;
         5'd12: v = 26'sd917;
         5'd13: v = 26'sd458;
         5'd14: v = 26'sd229;
         5'd15: v = 26'sd115;
         5'd16: v = 26'sd57;
         5'd17: v = 26'sd29;
         5'd18: v = 26'sd14;
         5'd19: v = 26'sd7;
         5'd20: v = 26'sd4;
         5'd21: v = 26'sd2;
         5'd22: v = 26'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/rme_sqrt_cell.sv
// One stage of a pipelined restoring square root that also carries the matrix along.
`default_nettype none
module rme_sqrt_cell #(
   parameter int STEP = 0
) (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic [28:0]          rem_in,
   input  wire logic [14:0]          root_in,
   input  wire rme_pkg::req_word_type mat_in,
   output logic [28:0]               rem_out,
   output logic [14:0]               root_out,
   output rme_pkg::req_word_type     mat_out
);
   // Bit 14-STEP of the root is resolved here.
   localparam int B = 14 - STEP;
   logic [30:0] trial;
   logic [30:0] rem_w;
   logic [28:0] rem_ff, rem_in_n;
   logic [14:0] root_ff, root_in_n;
   rme_pkg::req_word_type mat_ff;

   always_comb begin
      // (2R + 2^B) * 2^B is what setting bit B adds to the square of the partial root R.
      trial = ((31'(root_in) << 1) + (31'd1 << B)) << B;
      rem_w = 31'(rem_in);
      if (rem_w >= trial) begin
         rem_in_n = 29'(rem_w - trial);
         root_in_n = root_in | (15'd1 << B);
      end else begin
         rem_in_n = rem_in;
         root_in_n = root_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in_n;
         root_ff <= root_in_n;
         mat_ff  <= mat_in;
      end
   end

   assign rem_out = rem_ff;
   assign root_out = root_ff;
   assign mat_out = mat_ff;
endmodule
`default_nettype wire

>>> rtl/core/rme_cordic_cell.sv
// One vectoring CORDIC stage for three angle lanes at once.
`default_nettype none
module rme_cordic_cell #(
   parameter int STEP = 0
) (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic                          lock_in,
   input  wire logic signed [rme_pkg::CW-1:0] x_in [3],
   input  wire logic signed [rme_pkg::CW-1:0] y_in [3],
   input  wire logic signed [rme_pkg::ZW-1:0] z_in [3],
   output logic                               lock_out,
   output logic signed [rme_pkg::CW-1:0]      x_out [3],
   output logic signed [rme_pkg::CW-1:0]      y_out [3],
   output logic signed [rme_pkg::ZW-1:0]      z_out [3]
);
   logic signed [rme_pkg::CW-1:0] x_ff [3], y_ff [3];
   logic signed [rme_pkg::ZW-1:0] z_ff [3];
   logic signed [rme_pkg::CW-1:0] x_in_n [3], y_in_n [3];
   logic signed [rme_pkg::ZW-1:0] z_in_n [3];
   logic lock_ff;
   logic signed [rme_pkg::ZW-1:0] ang;

   assign ang = rme_pkg::atan_entry(5'(STEP));

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (y_in[k] > 0) begin
            x_in_n[k] = x_in[k] + (y_in[k] >>> STEP);
            y_in_n[k] = y_in[k] - (x_in[k] >>> STEP);
            z_in_n[k] = z_in[k] + ang;
         end else begin
            x_in_n[k] = x_in[k] - (y_in[k] >>> STEP);
            y_in_n[k] = y_in[k] + (x_in[k] >>> STEP);
            z_in_n[k] = z_in[k] - ang;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in_n;
         y_ff <= y_in_n;
         z_ff <= z_in_n;
         lock_ff <= lock_in;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
   assign lock_out = lock_ff;
endmodule
`default_nettype wire

>>> rtl/core/rotation_matrix_to_euler_core.sv
// Top level of the rotation matrix to Euler angle converter.
// Throughput: one word per cycle; the whole pipeline of cells advances while the
// output register is empty or being taken.
// Reset clears all valid flags and sets the lock threshold to 16; data registers are not reset.
`default_nettype none
module rotation_matrix_to_euler_core #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire rme_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rme_pkg::rsp_word_type      rsp_word,
   input  wire logic                  csr_write,
   input  wire logic [14:0]           csr_data
);
   localparam int NS = (CORDIC_STAGES > rme_pkg::TABLE_LEN) ? rme_pkg::TABLE_LEN
                       : CORDIC_STAGES;
   // Stages: input reg, 15 root cells, setup reg, NS cordic cells, output reg.
   localparam int DEPTH = 18 + NS;
   localparam int CW = rme_pkg::CW;
   localparam int ZW = rme_pkg::ZW;

   logic [14:0] thresh_ff;
   logic [DEPTH-1:0] vld_ff;
   logic adv;

   assign adv = !(vld_ff[DEPTH-1] && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= rme_pkg::THRESH_RESET;
         vld_ff <= '0;
      end else begin
         if (csr_write) thresh_ff <= csr_data;
         if (adv) vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   // Input register: clamp r02 and subtract its square from one (2^28).
   rme_pkg::req_word_type in_clamped;
   logic [28:0] sq_in, sq_ff;
   logic signed [15:0] c02;
   always_comb begin
      in_clamped = req_word;
      if (req_word.r02 > 16'sd16384) c02 = 16'sd16384;
      else if (req_word.r02 < -16'sd16384) c02 = -16'sd16384;
      else c02 = req_word.r02;
      in_clamped.r02 = c02;
      sq_in = rme_pkg::ONE_SQ - 29'(32'(c02) * 32'(c02));
   end
   rme_pkg::req_word_type m0_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         m0_ff <= in_clamped;
         sq_ff <= sq_in;
      end
   end

   logic [28:0] rem [16];
   logic [14:0] root [16];
   rme_pkg::req_word_type mat [16];
   assign rem[0] = sq_ff;
   assign root[0] = '0;
   assign mat[0] = m0_ff;
   for (genvar s = 0; s < 15; s++) begin : g_sqrt
      rme_sqrt_cell #(.STEP(s)) u_cell (
         .clock(clock), .en(adv),
         .rem_in(rem[s]), .root_in(root[s]), .mat_in(mat[s]),
         .rem_out(rem[s+1]), .root_out(root[s+1]), .mat_out(mat[s+1])
      );
   end

   // Setup: pick the lanes, pre-rotate left-half vectors, flag zero vectors.
   logic signed [15:0] ly [3], lx [3];
   logic lock_c;
   logic signed [CW-1:0] sx_in [3], sy_in [3];
   logic signed [ZW-1:0] sz_in [3];
   logic [2:0] zero_in, zero_ff;
   always_comb begin
      lock_c = !(root[15] > thresh_ff);
      ly[0] = mat[15].r02; lx[0] = 16'($signed({1'b0, root[15]}));
      ly[1] = lock_c ? mat[15].r10 : mat[15].r01;
      lx[1] = lock_c ? mat[15].r11 : mat[15].r00;
      ly[2] = mat[15].r12; lx[2] = mat[15].r22;
      for (int k = 0; k < 3; k++) begin
         zero_in[k] = (lx[k] == 0) && (ly[k] == 0);
         if (lx[k] < 0) begin
            sx_in[k] = -(CW'(lx[k]) <<< 8);
            sy_in[k] = -(CW'(ly[k]) <<< 8);
            sz_in[k] = (ly[k] >= 0) ? rme_pkg::HALF_TURN : -rme_pkg::HALF_TURN;
         end else begin
            sx_in[k] = CW'(lx[k]) <<< 8;
            sy_in[k] = CW'(ly[k]) <<< 8;
            sz_in[k] = '0;
         end
      end
   end

   logic signed [CW-1:0] cx [NS+1][3], cy [NS+1][3];
   logic signed [ZW-1:0] cz [NS+1][3];
   logic clk_lock [NS+1];
   logic [2:0] zr [NS+1];
   logic lock0_ff;
   logic signed [CW-1:0] sx_ff [3], sy_ff [3];
   logic signed [ZW-1:0] sz_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         sx_ff <= sx_in; sy_ff <= sy_in; sz_ff <= sz_in;
         lock0_ff <= lock_c;
         zero_ff <= zero_in;
      end
   end
   assign cx[0] = sx_ff;
   assign cy[0] = sy_ff;
   assign cz[0] = sz_ff;
   assign clk_lock[0] = lock0_ff;
   assign zr[0] = zero_ff;

   for (genvar s = 0; s < NS; s++) begin : g_cordic
      logic [2:0] zr_ff;
      rme_cordic_cell #(.STEP(s)) u_cell (
         .clock(clock), .en(adv), .lock_in(clk_lock[s]),
         .x_in(cx[s]), .y_in(cy[s]), .z_in(cz[s]),
         .lock_out(clk_lock[s+1]),
         .x_out(cx[s+1]), .y_out(cy[s+1]), .z_out(cz[s+1])
      );
      always_ff @(posedge clock) begin
         if (adv) zr_ff <= zr[s];
      end
      assign zr[s+1] = zr_ff;
   end

   // Round, clamp, negate pitch (and yaw under gimbal lock) and zero roll under lock into the output register.
   logic signed [15:0] ang [3];
   logic signed [ZW-1:0] rz;
   rme_pkg::rsp_word_type out_in, out_ff;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rz = (cz[NS][k] + ZW'(256)) >>> 9;
         if (zr[NS][k]) ang[k] = '0;
         else if (rz > ZW'(rme_pkg::OUT_LIMIT)) ang[k] = rme_pkg::OUT_LIMIT;
         else if (rz < -ZW'(rme_pkg::OUT_LIMIT)) ang[k] = -rme_pkg::OUT_LIMIT;
         else ang[k] = 16'(rz);
      end
      out_in.pitch_angle = -ang[0];
      out_in.yaw_angle = clk_lock[NS] ? -ang[1] : ang[1];
      out_in.roll_angle = clk_lock[NS] ? 16'sd0 : ang[2];
      out_in.gimbal_lock = clk_lock[NS];
   end
   always_ff @(posedge clock) begin
      if (adv) out_ff <= out_in;
   end

   assign rsp_valid = vld_ff[DEPTH-1];
   assign rsp_word = out_ff;
endmodule
`default_nettype wire

>>> rtl/core/rme_checker.sv
// Port-level checks for the Euler angle core, bound to the top level.
`default_nettype none
module rme_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire rme_pkg::rsp_word_type rsp_word
);
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");
   a_stall_path: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output back pressure");
   a_lock_roll: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.gimbal_lock |-> rsp_word.roll_angle == 16'sd0)
      else $error("roll not zero under gimbal lock");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.pitch_angle <= 16'sd11520 && rsp_word.pitch_angle >= -16'sd11520)
      else $error("pitch beyond ninety degrees");
endmodule

bind rotation_matrix_to_euler_core rme_checker u_rme_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
);
`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the rotation matrix to Euler angle core.
module tb;

   localparam int STAGES = 16;
   localparam int LATENCY = 17 + STAGES;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   rme_pkg::req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rme_pkg::rsp_word_type rsp_word;
   logic csr_write = 1'b0;
   logic [14:0] csr_data = '0;

   rotation_matrix_to_euler_core #(.CORDIC_STAGES(STAGES)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_write(csr_write), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   logic [14:0] lock_threshold = rme_pkg::THRESH_RESET;
   rme_pkg::rsp_word_type angles_due[$];
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;
   int hold_asks = 0;
   int hold_taken = 0;

   // The atan table, kept separately from the package.
   function automatic longint arctan_step(input int i);
      longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
         29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
      return tab[i];
   endfunction

   function automatic int vector_angle(input int y, input int x);
      longint xv, yv, z, dx, dy, r;
      xv = longint'(x) * 256;
      yv = longint'(y) * 256;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (xv < 0) begin
         z = (yv >= 0) ? (longint'(180) <<< 16) : -(longint'(180) <<< 16);
         xv = -xv;
         yv = -yv;
      end
      for (int i = 0; i < STAGES && i < 24; i++) begin
         dx = yv >>> i;
         dy = xv >>> i;
         if (yv > 0) begin
            xv += dx; yv -= dy; z += arctan_step(i);
         end else begin
            xv -= dx; yv += dy; z -= arctan_step(i);
         end
      end
      r = (z + 256) >>> 9;
      if (r > 23040) r = 23040;
      if (r < -23040) r = -23040;
      return int'(r);
   endfunction

   function automatic int int_sqrt(input longint n);
      longint s;
      s = 0;
      while ((s + 1) * (s + 1) <= n) s = s + 1;
      return int'(s);
   endfunction

   function automatic rme_pkg::rsp_word_type euler_angles(input rme_pkg::req_word_type m);
      rme_pkg::rsp_word_type a;
      int r02, cp;
      r02 = m.r02;
      if (r02 > 16384) r02 = 16384;
      if (r02 < -16384) r02 = -16384;
      cp = int_sqrt(longint'(16384) * 16384 - longint'(r02) * r02);
      a.pitch_angle = 16'(-vector_angle(r02, cp));
      a.gimbal_lock = !(cp > lock_threshold);
      if (!a.gimbal_lock) begin
         a.yaw_angle = 16'(vector_angle(m.r01, m.r00));
         a.roll_angle = 16'(vector_angle(m.r12, m.r22));
      end else begin
         a.yaw_angle = 16'(-vector_angle(m.r10, m.r11));
         a.roll_angle = '0;
      end
      return a;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (angles_due.size() == 0) begin
            report_mismatch("unexpected word", 0, 0);
         end else begin
            rme_pkg::rsp_word_type want;
            want = angles_due.pop_front();
            if (rsp_word.pitch_angle !== want.pitch_angle)
               report_mismatch("pitch", rsp_word.pitch_angle, want.pitch_angle);
            if (rsp_word.yaw_angle !== want.yaw_angle)
               report_mismatch("yaw", rsp_word.yaw_angle, want.yaw_angle);
            if (rsp_word.roll_angle !== want.roll_angle)
               report_mismatch("roll", rsp_word.roll_angle, want.roll_angle);
            if (rsp_word.gimbal_lock !== want.gimbal_lock)
               report_mismatch("lock", rsp_word.gimbal_lock, want.gimbal_lock);
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off when one is asked for.
   always @(posedge clock) begin
      if (hold_asks != hold_taken) begin
         hold_taken <= hold_asks;
         hold_cycles <= 3 * LATENCY;
         rsp_stall <= 1'b1;
      end else if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Valid stays high after an accepted word; the caller drops it when a burst ends.
   task automatic send_matrix(input rme_pkg::req_word_type m);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= m;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      angles_due.insert(angles_due.size(), euler_angles(m));
   endtask

   task automatic drain_results;
      while (angles_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic set_threshold(input logic [14:0] value);
      drain_results();
      csr_write <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      lock_threshold = value;
   endtask

   function automatic logic signed [15:0] any_element();
      case ($urandom_range(7))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sd16384;
         3: return -16'sd16384;
         4: return 16'sd0;
         default: return 16'($urandom);
      endcase
   endfunction

   // A matrix built from random angles, mostly well-formed, sometimes noise.
   function automatic rme_pkg::req_word_type random_matrix();
      rme_pkg::req_word_type m;
      real p, y, r, k;
      if ($urandom_range(9) < 3) begin
         m = 112'({$urandom, $urandom, $urandom, $urandom});
         m.r02 = any_element();
         return m;
      end
      k = 3.14159265358979 / 180.0;
      p = (real'($urandom_range(18000)) / 100.0 - 90.0) * k;
      if ($urandom_range(7) == 0) p = ($urandom_range(1) ? 90.0 : -90.0) * k;
      y = (real'($urandom_range(36000)) / 100.0 - 180.0) * k;
      r = (real'($urandom_range(36000)) / 100.0 - 180.0) * k;
      m.r00 = 16'($rtoi(16384.0 * $cos(p) * $cos(y)));
      m.r01 = 16'($rtoi(16384.0 * $cos(p) * $sin(y)));
      m.r02 = 16'($rtoi(-16384.0 * $sin(p)));
      m.r10 = 16'($rtoi(16384.0 * ($sin(r) * $sin(p) * $cos(y) - $cos(r) * $sin(y))));
      m.r11 = 16'($rtoi(16384.0 * ($sin(r) * $sin(p) * $sin(y) + $cos(r) * $cos(y))));
      m.r12 = 16'($rtoi(16384.0 * $sin(r) * $cos(p)));
      m.r22 = 16'($rtoi(16384.0 * $cos(r) * $cos(p)));
      return m;
   endfunction

   typedef struct {
      rme_pkg::req_word_type m;
      logic check_fixed;
      rme_pkg::rsp_word_type want;
   } directed_row_type;

   directed_row_type directed_rows[] = '{
      '{'{16384, 0, 0, 0, 16384, 0, 16384}, 1'b1, '{0, 0, 0, 1'b0}},
      '{'{0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 1'b0}},
      '{'{0, 0, 16384, 0, 16384, 0, 0}, 1'b1, '{-11520, 0, 0, 1'b1}},
      '{'{0, 0, -16384, 0, 16384, 0, 0}, 1'b1, '{11520, 0, 0, 1'b1}},
      '{'{0, 0, 32767, 0, 0, 0, 0}, 1'b1, '{-11520, 0, 0, 1'b1}},
      '{'{0, 0, -32768, 0, 0, 0, 0}, 1'b1, '{11520, 0, 0, 1'b1}},
      '{'{-16384, 0, 0, 0, 16384, 0, -16384}, 1'b0, '0},
      '{'{-16384, -1, 0, 0, 16384, 1, -16384}, 1'b0, '0},
      '{'{-32768, 32767, 0, 0, 0, -32768, 32767}, 1'b0, '0},
      '{'{32767, -32768, 100, 32767, -32768, 32767, -32768}, 1'b0, '0},
      '{'{11585, 11585, 16383, 5, -7, 9, 0}, 1'b0, '0},
      '{'{0, 16384, -16380, -16384, 0, 0, 16384}, 1'b0, '0},
      '{'{-1, 0, 8192, 0, -1, -1, 0}, 1'b0, '0},
      '{'{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555},
         1'b0, '0},
      '{'{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa},
         1'b0, '0}
   };

   initial begin
      #50_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      logic [14:0] thresholds[5] = '{15'd0, 15'd16384, 15'd32767, 15'd1000, 15'd200};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fixed answers hold at the reset threshold.
      foreach (directed_rows[i]) begin
         send_matrix(directed_rows[i].m);
         if (directed_rows[i].check_fixed)
            angles_due[$] = directed_rows[i].want;
      end
      req_valid <= 1'b0;
      drain_results();

      foreach (thresholds[s]) begin
         set_threshold(thresholds[s]);
         for (int pass = 0; pass < 3; pass++) begin
            send_idle_pct = (pass == 0) ? 38 : (pass == 1) ? 54 : 0;
            recv_idle_pct = (pass == 0) ? 54 : (pass == 1) ? 38 : 0;
            if (pass == 2 && s == 0) begin
               // Long receiver hold-off while words keep coming, so the core fills.
               hold_asks = hold_asks + 1;
               repeat (2) @(posedge clock);
            end
            for (int n = 0; n < 87; n++) begin
               send_matrix(random_matrix());
            end
            req_valid <= 1'b0;
            // The sender waits here for every outstanding word.
            while (angles_due.size() != 0) @(posedge clock);
         end
      end

      send_idle_pct = 0;
      recv_idle_pct = 0;
      drain_results();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

>>> sim.f
rtl/core/rme_pkg.sv
rtl/core/rme_sqrt_cell.sv
rtl/core/rme_cordic_cell.sv
rtl/core/rotation_matrix_to_euler_core.sv
rtl/core/rme_checker.sv
test/tb.sv
